>>> rtl/ptimer_pkg.sv
// ----------------------------------------------------------------------------
// ptimer_pkg
// shared widths, codes and transaction types of the periodic timer with
// missed-tick counting
// ----------------------------------------------------------------------------
package ptimer_pkg;

  localparam int TIME_WIDTH    = 24;
  localparam int COUNT_WIDTH   = 32;
  // elapsed time and goal carry one extra bit
  localparam int GOAL_WIDTH    = TIME_WIDTH + 1;
  // elapsed plus time step before reduction
  localparam int DIV_WIDTH     = TIME_WIDTH + 2;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_WIDTH + 1);
  localparam int SUM_WIDTH     = ((DIV_WIDTH > COUNT_WIDTH) ? DIV_WIDTH : COUNT_WIDTH) + 1;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CALL    = 2'd1,
    OP_SET     = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_PLAY    = 2'd0,
    ST_PAUSE   = 2'd1,
    ST_ABORTED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_FIRST_DELAY = 2'd0,
    CFG_PERIOD      = 2'd1,
    CFG_LOOPED      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e                   opcode;
    logic [TIME_WIDTH-1:0] time_step;
    logic                  call_once;
    logic [1:0]            new_status;
  } item_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] fired;
    logic [COUNT_WIDTH-1:0] pending_out;
    logic                   ready_res;
    logic [1:0]             status_out;
  } result_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/ptimer_div.sv
// ----------------------------------------------------------------------------
// ptimer_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptimer_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ptimer_pkg::DIV_WIDTH-1:0]    dividend_i,
  input  logic [ptimer_pkg::GOAL_WIDTH-1:0]   divisor_i,
  output ptimer_pkg::div_stat_t               stat_o,
  output logic [ptimer_pkg::DIV_WIDTH-1:0]    quotient_o,
  output logic [ptimer_pkg::GOAL_WIDTH-1:0]   remainder_o
);

  localparam int DW = ptimer_pkg::DIV_WIDTH;
  localparam int GW = ptimer_pkg::GOAL_WIDTH;
  localparam int CW = ptimer_pkg::DIV_CNT_WIDTH;

  // acc_q shifts dividend bits out at the top and quotient bits in at the bottom
  logic [DW-1:0] acc_q, acc_d;
  logic [GW-1:0] rem_q, rem_d;
  logic [GW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;

  logic [GW:0]   shifted;
  logic [GW+1:0] diff;
  logic          qbit;

  always_comb begin
    shifted = {rem_q, acc_q[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    qbit    = ~diff[GW+1];
    acc_d   = acc_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[DW-2:0], qbit};
      // a kept partial remainder is below the divisor and fits
      rem_d = qbit ? diff[GW-1:0] : shifted[GW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = ~busy_q;
  assign quotient_o  = acc_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/periodic_timer_missed_tick_counter.sv
// ----------------------------------------------------------------------------
// periodic_timer_missed_tick_counter
// periodic timer with a first delay that counts expiries not yet serviced
// ----------------------------------------------------------------------------
// Every input transaction gives exactly one result transaction. A tick that
// reaches a nonzero goal while playing waits in S_DIV for the serial divider,
// which forms (elapsed + time step) / goal one quotient bit per cycle; every other
// transaction is answered from S_EXEC. One transaction is worked on at a time,
// and the next one is taken in while a finished result still waits in the
// output register. Register writes take effect at the next restart, except
// that the period is read when a reached goal switches over to it and the
// looped flag is read at each call. Pending counts saturate at all ones; a
// zero goal saturates them at once without dividing.
module periodic_timer_missed_tick_counter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input transactions
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  ptimer_pkg::item_t                     in_item_i,
  // result transactions
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output ptimer_pkg::result_t                   out_result_o,
  // register writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ptimer_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [ptimer_pkg::TIME_WIDTH-1:0]     cfg_data_i
);

  localparam int TW = ptimer_pkg::TIME_WIDTH;
  localparam int CW = ptimer_pkg::COUNT_WIDTH;
  localparam int GW = ptimer_pkg::GOAL_WIDTH;
  localparam int DW = ptimer_pkg::DIV_WIDTH;
  localparam int SW = ptimer_pkg::SUM_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_e;

  // configuration registers
  logic [TW-1:0] first_delay_q;
  logic [TW-1:0] period_q;
  logic          looped_q;

  // timer state
  state_e              state_q, state_d;
  ptimer_pkg::item_t   item_q, item_d;
  logic [GW-1:0]       elapsed_q, elapsed_d;
  logic [GW-1:0]       goal_q, goal_d;
  logic [CW-1:0]       pending_q, pending_d;
  ptimer_pkg::status_e status_q, status_d;
  logic                out_valid_q, out_valid_d;
  ptimer_pkg::result_t result_q, result_d;

  // divider hookup
  logic                  div_start;
  ptimer_pkg::div_stat_t div_stat;
  logic [DW-1:0]         quotient;
  logic [GW-1:0]         remainder;

  logic          slot_free;
  logic          playing;
  logic [DW-1:0] tick_sum;
  logic          reached;
  logic          need_div;
  logic [SW-1:0] acc_sum;
  logic [CW-1:0] pending_sat;
  logic [CW-1:0] fired;
  logic          emit;

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;

  // output register is free or being emptied this cycle
  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign playing   = (status_q == ptimer_pkg::ST_PLAY);
  assign tick_sum  = {1'b0, elapsed_q} + {2'b00, item_q.time_step};
  assign reached   = (tick_sum >= {1'b0, goal_q});
  assign need_div  = (item_q.opcode == ptimer_pkg::OP_TICK) && playing && reached &&
                     (goal_q != '0);

  // saturating add of the expiries counted by the divider
  assign acc_sum     = SW'(quotient) + SW'(pending_q);
  assign pending_sat = (acc_sum >= SW'(ptimer_pkg::COUNT_MAX)) ? ptimer_pkg::COUNT_MAX :
                       acc_sum[CW-1:0];

  ptimer_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (tick_sum),
    .divisor_i   (goal_q),
    .stat_o      (div_stat),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    elapsed_d   = elapsed_q;
    goal_d      = goal_q;
    pending_d   = pending_q;
    status_d    = status_q;
    fired       = '0;
    emit        = 1'b0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (need_div) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (slot_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          unique case (item_q.opcode)
            ptimer_pkg::OP_TICK: begin
              if (playing) begin
                if (reached) begin
                  // zero goal: every expiry at once
                  pending_d = ptimer_pkg::COUNT_MAX;
                  elapsed_d = '0;
                  goal_d    = {1'b0, period_q};
                end else begin
                  elapsed_d = tick_sum[GW-1:0];
                end
              end
            end
            ptimer_pkg::OP_CALL: begin
              if (playing) begin
                pending_d = '0;
                if (!looped_q) begin
                  fired    = CW'(1);
                  status_d = ptimer_pkg::ST_ABORTED;
                end else if (item_q.call_once) begin
                  fired = CW'(1);
                end else begin
                  fired = pending_q;
                end
              end
            end
            ptimer_pkg::OP_SET: begin
              // the unused status code leaves the timer as it is
              if (item_q.new_status <= ptimer_pkg::ST_ABORTED) begin
                status_d = ptimer_pkg::status_e'(item_q.new_status);
              end
            end
            ptimer_pkg::OP_RESTART: begin
              status_d  = ptimer_pkg::ST_PLAY;
              elapsed_d = '0;
              goal_d    = {1'b0, first_delay_q} + {1'b0, period_q};
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done && slot_free) begin
          emit      = 1'b1;
          state_d   = S_IDLE;
          pending_d = pending_sat;
          elapsed_d = remainder;
          goal_d    = {1'b0, period_q};
        end
      end
      default: state_d = S_IDLE;
    endcase

    result_d = result_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      result_d.fired       = fired;
      result_d.pending_out = pending_d;
      result_d.ready_res   = (status_d == ptimer_pkg::ST_PLAY) && (pending_d != '0);
      result_d.status_out  = status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      elapsed_q     <= '0;
      goal_q        <= GW'(1);
      pending_q     <= '0;
      status_q      <= ptimer_pkg::ST_PLAY;
      first_delay_q <= '0;
      period_q      <= TW'(1);
      looped_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      elapsed_q   <= elapsed_d;
      goal_q      <= goal_d;
      pending_q   <= pending_d;
      status_q    <= status_d;
      // register writes, unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          ptimer_pkg::CFG_FIRST_DELAY: first_delay_q <= cfg_data_i;
          ptimer_pkg::CFG_PERIOD:      period_q      <= cfg_data_i;
          ptimer_pkg::CFG_LOOPED:      looped_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    result_q <= result_d;
  end

endmodule

>>> rtl/ptimer_chk.sv
// ----------------------------------------------------------------------------
// ptimer_chk
// port-level checks of the periodic timer, bound to the top level
// ----------------------------------------------------------------------------
module ptimer_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input ptimer_pkg::result_t                   out_result_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_result_o))
    else $error("stalled result changed");

  // ready flag agrees with status and pending count
  a_ready_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_result_o.ready_res ==
      ((out_result_o.status_out == ptimer_pkg::ST_PLAY) && (out_result_o.pending_out != '0)))
    else $error("ready flag inconsistent");

  // any callback firing empties the pending count
  a_fire_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_result_o.fired != '0) |-> out_result_o.pending_out == '0)
    else $error("pending left after firing");

  // firing leaves the timer playing or aborted, never paused
  a_fire_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_result_o.fired != '0) |->
      out_result_o.status_out != ptimer_pkg::ST_PAUSE)
    else $error("fired while paused");

endmodule

bind periodic_timer_missed_tick_counter ptimer_chk u_ptimer_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_result_o (out_result_o)
);

>>> verif/periodic_timer_missed_tick_counter_tb.sv
// ----------------------------------------------------------------------------
// periodic_timer_missed_tick_counter_tb
// self-checking bench for the periodic timer with missed-tick counting
// ----------------------------------------------------------------------------
// A directed opening walks through the corner behavior: widest time steps,
// draining and single-fire calls, pause and abort handling, an ignored status
// code, one-shot aborts, a zero goal and pending saturation. Random phases
// then run under several register settings, most with random gaps and stalls
// on both channels. Every result transaction is checked field by field against
// a timer predictor kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module periodic_timer_missed_tick_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptimer_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 800_000;
  localparam int HOLD_CYCLES   = 250;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
  // status code outside the enum, which a set transaction must ignore
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // --------------------------------------------------------------------------
  // scoreboard: timer predictor plus the queue of results still to arrive
  // --------------------------------------------------------------------------
  class timer_scoreboard;
    // register copies
    logic [TIME_WIDTH-1:0]  first_delay;
    logic [TIME_WIDTH-1:0]  period;
    logic                   looped;
    // timer state
    logic [GOAL_WIDTH-1:0]  elapsed;
    logic [GOAL_WIDTH-1:0]  goal;
    logic [COUNT_WIDTH-1:0] pending;
    status_e                run_status;
    result_t                timer_reports_q[$];
    // run statistics
    int                     errors;
    int                     checked;
    int                     expiries;
    int                     saturations;
    int                     aborts;
    longint                 fired_total;

    function new();
      first_delay = '0;
      period      = TIME_WIDTH'(1);
      looped      = 1'b1;
      elapsed     = '0;
      goal        = GOAL_WIDTH'(1);
      pending     = '0;
      run_status  = ST_PLAY;
      errors      = 0;
      checked     = 0;
      expiries    = 0;
      saturations = 0;
      aborts      = 0;
      fired_total = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [TIME_WIDTH-1:0] data);
      case (idx)
        CFG_FIRST_DELAY: first_delay = data;
        CFG_PERIOD:      period      = data;
        CFG_LOOPED:      looped      = data[0];
        default: ;
      endcase
    endfunction

    // saturating add of newly missed expiries
    function void add_missed(logic [DIV_WIDTH-1:0] n);
      if (n >= COUNT_MAX - pending) begin
        pending = COUNT_MAX;
        saturations++;
      end else begin
        pending = pending + n;
      end
    endfunction

    function result_t step_timer(item_t it);
      result_t              r;
      logic [DIV_WIDTH-1:0] sum;
      r = '0;
      case (it.opcode)
        OP_TICK: begin
          if (run_status == ST_PLAY) begin
            sum = DIV_WIDTH'(elapsed) + DIV_WIDTH'(it.time_step);
            if (sum >= DIV_WIDTH'(goal)) begin
              if (goal == '0) begin
                // zero goal: every tick counts as endless expiries
                pending = COUNT_MAX;
                elapsed = '0;
                saturations++;
              end else begin
                add_missed(sum / DIV_WIDTH'(goal));
                elapsed = GOAL_WIDTH'(sum % DIV_WIDTH'(goal));
              end
              expiries++;
              // period register is read right here as well as at restart
              goal = GOAL_WIDTH'(period);
            end else begin
              elapsed = GOAL_WIDTH'(sum);
            end
          end
        end
        OP_CALL: begin
          if (run_status == ST_PLAY) begin
            if (!looped) begin
              r.fired    = COUNT_WIDTH'(1);
              pending    = '0;
              run_status = ST_ABORTED;
              aborts++;
            end else if (it.call_once) begin
              r.fired = COUNT_WIDTH'(1);
              pending = '0;
            end else begin
              r.fired = pending;
              pending = '0;
            end
          end
        end
        OP_SET: begin
          if (it.new_status <= ST_ABORTED) run_status = status_e'(it.new_status);
        end
        default: begin
          run_status = ST_PLAY;
          elapsed    = '0;
          goal       = GOAL_WIDTH'(first_delay) + GOAL_WIDTH'(period);
        end
      endcase
      fired_total   += r.fired;
      r.pending_out = pending;
      r.ready_res   = (run_status == ST_PLAY) && (pending != '0);
      r.status_out  = run_status;
      return r;
    endfunction

    function void note_item(item_t it);
      timer_reports_q.push_back(step_timer(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (timer_reports_q.size() == 0) begin
        $error("result transaction with nothing awaited: %h", got);
        errors++;
        return;
      end
      want = timer_reports_q.pop_front();
      checked++;
      if (got.fired !== want.fired) begin
        $error("fired: expected %0d, got %0d", want.fired, got.fired);
        errors++;
      end
      if (got.pending_out !== want.pending_out) begin
        $error("pending_out: expected %0d, got %0d", want.pending_out, got.pending_out);
        errors++;
      end
      if (got.ready_res !== want.ready_res) begin
        $error("ready_res: expected %0b, got %0b", want.ready_res, got.ready_res);
        errors++;
      end
      if (got.status_out !== want.status_out) begin
        $error("status_out: expected %0d, got %0d", want.status_out, got.status_out);
        errors++;
      end
    endfunction

    function int awaiting();
      return timer_reports_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  item_t                    in_item;
  logic                     out_valid;
  logic                     out_stall;
  result_t                  out_result;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [TIME_WIDTH-1:0]    cfg_data;

  timer_scoreboard sb;
  bit              calm;       // no gaps and no stalls while set
  bit              hold_req;   // asks the receiver for one long hold-off
  int unsigned     cycles;
  int              n_settings;

  periodic_timer_missed_tick_counter u_top (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_item_i    (in_item),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_result_o (out_result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // generous bound: every tick hitting the goal, worst gaps and stalls on top
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still awaited", cycles, sb.awaiting());
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // idle lengths: mostly none or short, now and then long
  // --------------------------------------------------------------------------
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // result side: stall pattern in runs, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int   run_left;
    int   hold_left;
    logic nxt;
    out_stall = 1'b0;
    run_left  = 0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (hold_req) begin
        // sender keeps offering meanwhile, so the block backs up
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        nxt       = 1'b1;
      end else if (calm) begin
        nxt = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        nxt = out_stall;
      end else begin
        nxt      = ($urandom_range(0, 99) < 30);
        run_left = idle_length();
      end
      out_stall <= nxt;
    end
  end

  // sampled before the edge updates land, so ordering within the step is moot
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_result);
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  function automatic item_t make_item(op_e op, logic [TIME_WIDTH-1:0] step = '0,
                                      logic once = 1'b0, logic [1:0] st = ST_PLAY);
    item_t it;
    it.opcode     = op;
    it.time_step  = step;
    it.call_once  = once;
    it.new_status = st;
    return it;
  endfunction

  // entered at a falling edge; valid stays high into the next transaction
  // when no gap follows
  task automatic send_item(item_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    @(negedge clk);
    gap = calm ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender pause until every awaited result is in
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaiting() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TIME_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // registers only change with the block idle
  task automatic write_regs(logic [TIME_WIDTH-1:0] fd, logic [TIME_WIDTH-1:0] per,
                            logic loop);
    wait_drained();
    write_reg(CFG_FIRST_DELAY, fd);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_LOOPED, TIME_WIDTH'(loop));
    n_settings++;
  endtask

  // one random phase under fixed registers; starts with a restart so that
  // the new first delay and period are in force
  task automatic run_phase(int unsigned fd, int unsigned per, bit loop, int n,
                           bit hold, bit quiet);
    int                    k;
    int                    r;
    int unsigned           per_span;
    int unsigned           goal_span;
    op_e                   op;
    logic [TIME_WIDTH-1:0] step;
    logic [1:0]            st;
    write_regs(TIME_WIDTH'(fd), TIME_WIDTH'(per), loop);
    calm = quiet;
    if (hold) hold_req = 1'b1;
    send_item(make_item(OP_RESTART));
    per_span  = (per * 2 > TIME_MAX) ? TIME_MAX : per * 2;
    goal_span = (fd + per > TIME_MAX) ? TIME_MAX : fd + per;
    for (k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      op = (r < 55) ? OP_TICK : (r < 72) ? OP_CALL : (r < 88) ? OP_SET : OP_RESTART;
      // steps mostly scaled to the period or goal so expiries come often, else tiny or random
      case ($urandom_range(0, 3))
        0:       step = TIME_WIDTH'($urandom_range(0, per_span));
        1:       step = TIME_WIDTH'($urandom_range(0, 7));
        2:       step = TIME_WIDTH'($urandom());
        default: step = TIME_WIDTH'($urandom_range(0, goal_span));
      endcase
      // play most of the time, any code including the unknown one otherwise
      st = $urandom_range(0, 1) ? ST_PLAY : 2'($urandom_range(0, 3));
      send_item(make_item(op, step, 1'($urandom_range(0, 1)), st));
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_ni     = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    n_settings = 1;
    sb         = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // reset registers: no first delay, period of one, looped
    send_item(make_item(OP_TICK, '0));
    send_item(make_item(OP_TICK, TIME_MAX));               // widest step
    send_item(make_item(OP_CALL, '0, 1'b0));               // drain all pending
    send_item(make_item(OP_TICK, TIME_WIDTH'(3)));
    send_item(make_item(OP_CALL, '0, 1'b1));               // fire once and clear
    send_item(make_item(OP_CALL, '0, 1'b1));               // fires with none pending
    send_item(make_item(OP_SET, '0, 1'b0, ST_PAUSE));
    send_item(make_item(OP_TICK, TIME_WIDTH'(5)));         // ignored while paused
    send_item(make_item(OP_CALL, '0, 1'b0));               // fires nothing while paused
    send_item(make_item(OP_SET, '0, 1'b0, ST_UNKNOWN));    // ignored code
    send_item(make_item(OP_SET, '0, 1'b0, ST_PLAY));
    send_item(make_item(OP_SET, '0, 1'b0, ST_ABORTED));
    send_item(make_item(OP_SET, '0, 1'b0, ST_PAUSE));      // out of aborted
    send_item(make_item(OP_RESTART));

    // one-shot with the largest first delay and period
    write_regs(TIME_MAX, TIME_MAX, 1'b0);
    send_item(make_item(OP_RESTART));
    send_item(make_item(OP_TICK, TIME_MAX));
    send_item(make_item(OP_TICK, TIME_MAX));               // lands exactly on the goal
    send_item(make_item(OP_TICK, TIME_MAX));
    send_item(make_item(OP_CALL, '0, 1'b0));               // fires once then aborts
    send_item(make_item(OP_CALL, '0, 1'b0));               // aborted: nothing
    send_item(make_item(OP_RESTART));

    // zero goal saturates, then saturation through the add path
    write_regs('0, '0, 1'b1);
    send_item(make_item(OP_RESTART));
    send_item(make_item(OP_TICK, '0));
    write_regs('0, TIME_WIDTH'(5), 1'b1);
    send_item(make_item(OP_TICK, '0));                     // goal still zero, now period 5
    send_item(make_item(OP_TICK, TIME_WIDTH'(7)));         // add on a full count
    send_item(make_item(OP_CALL, '0, 1'b0));               // drain the full count

    // random phases across register settings
    run_phase(0, 1, 1'b1, 160, 1'b0, 1'b1);
    run_phase($urandom_range(0, 50), $urandom_range(1, 20), 1'b1, 180, 1'b0, 1'b0);
    run_phase(TIME_MAX, TIME_MAX, 1'b1, 160, 1'b1, 1'b0);
    run_phase($urandom_range(0, TIME_MAX), $urandom_range(1, TIME_MAX), 1'b0, 160,
              1'b0, 1'b0);
    run_phase(0, 0, 1'b1, 60, 1'b0, 1'b0);
    run_phase($urandom_range(0, TIME_MAX), $urandom_range(1, 64), 1'b1, 180, 1'b1, 1'b0);
    run_phase($urandom_range(0, 16), $urandom_range(1, 16), 1'b0, 160, 1'b0, 1'b0);
    run_phase($urandom_range(0, 4095), $urandom_range(1, 4095), 1'b1, 180, 1'b0, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d transactions under %0d register settings in %0d cycles",
             sb.checked, n_settings, cycles);
    $display("goals reached %0d, callbacks fired %0d, saturations %0d, one-shot aborts %0d",
             sb.expiries, sb.fired_total, sb.saturations, sb.aborts);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
